FILE: src/owbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, command codes, register indexes and segment timings of the
// single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned CntW  = 16;
  localparam int unsigned RegIdxW = 2;

  localparam logic [OpW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpW-1:0] OP_RESET  = 3'd1;
  localparam logic [OpW-1:0] OP_WRITE  = 3'd2;
  localparam logic [OpW-1:0] OP_READ   = 3'd3;
  localparam logic [OpW-1:0] OP_SLOT1  = 3'd4;
  localparam logic [OpW-1:0] OP_SLOT0  = 3'd5;
  localparam logic [OpW-1:0] OP_LONG   = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;

  localparam logic [RegIdxW-1:0] REG_RESET_LOW     = 2'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_RECOVERY = 2'd1;

  localparam logic [9:0]      RESET_LOW_DEFAULT     = 10'd500;
  localparam logic [CntW-1:0] LONG_RECOVERY_DEFAULT = 16'd13000;

  localparam logic [CntW-1:0] PRE_US        = 16'd250;
  localparam logic [CntW-1:0] WAIT_US       = 16'd60;
  localparam logic [CntW-1:0] SAMPLE_US     = 16'd60;
  localparam logic [CntW-1:0] HIGHWAIT_US   = 16'd180;
  localparam logic [CntW-1:0] TAIL_US       = 16'd420;
  localparam logic [CntW-1:0] SLOT_LONG_US  = 16'd60;
  localparam logic [CntW-1:0] SLOT_SHORT_US = 16'd1;
  localparam logic [CntW-1:0] LONG_ONE_US   = 16'd10;
  localparam logic [CntW-1:0] RD_LOW_US     = 16'd2;
  localparam logic [CntW-1:0] RD_REL_US     = 16'd14;
  localparam logic [CntW-1:0] RD_REC_US     = 16'd60;
  localparam logic [CntW-1:0] BYTE_TAIL_US  = 16'd30;
  localparam logic [7:0]      SAMPLE_WINDOW = 8'd60;
  localparam logic [3:0]      BITS_PER_BYTE = 4'd8;
  localparam logic [3:0]      BITS_PER_SLOT = 4'd1;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_PRE      = 13'b0000000000010,
    PH_RLOW     = 13'b0000000000100,
    PH_WAIT60   = 13'b0000000001000,
    PH_SAMPLE   = 13'b0000000010000,
    PH_HIGHWAIT = 13'b0000000100000,
    PH_TAIL420  = 13'b0000001000000,
    PH_BITLOW   = 13'b0000010000000,
    PH_BITREL   = 13'b0000100000000,
    PH_RDLOW    = 13'b0001000000000,
    PH_RDREL    = 13'b0010000000000,
    PH_RDREC    = 13'b0100000000000,
    PH_BYTETAIL = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [9:0]      reset_low_us;
    logic [CntW-1:0] long_recovery_us;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [7:0]     data_byte;
    logic           line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } result_t;

  typedef struct packed {
    phase_t          phase;
    logic [OpW-1:0]  operation;
    logic [CntW-1:0] us_counter;
    logic [7:0]      window_index;
    logic [3:0]      bit_count;
    logic [7:0]      shift_byte;
    logic            presence_flag;
    logic [7:0]      read_byte_reg;
  } seq_state_t;

  typedef struct packed {
    seq_state_t st;
    logic       done;
  } seq_step_t;

endpackage

FILE: src/owbm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_cfg
// Configuration register file: decodes write transactions into the reset
// pulse length and the long-pulse recovery time.
// ----------------------------------------------------------------------------
module owbm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [owbm_pkg::RegIdxW-1:0]     wr_index,
  input  logic [owbm_pkg::CntW-1:0]        wr_data,
  output owbm_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us     <= owbm_pkg::RESET_LOW_DEFAULT;
      cfg.long_recovery_us <= owbm_pkg::LONG_RECOVERY_DEFAULT;
    end else if (wr_en) begin
      case (wr_index)
        owbm_pkg::REG_RESET_LOW:     cfg.reset_low_us     <= wr_data[9:0];
        owbm_pkg::REG_LONG_RECOVERY: cfg.long_recovery_us <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/owbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_seq
// Bus sequencer: holds the operation state and advances it by one
// microsecond for each item, producing the result for that item.
// ----------------------------------------------------------------------------
module owbm_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  owbm_pkg::item_t   item,
  input  owbm_pkg::cfg_t    cfg,
  output owbm_pkg::result_t res
);

  owbm_pkg::seq_state_t state;
  owbm_pkg::seq_state_t state_next;
  owbm_pkg::seq_state_t s_start;
  owbm_pkg::seq_state_t s_work;
  owbm_pkg::seq_step_t  adv1;
  owbm_pkg::seq_step_t  adv2;
  logic                 is_cmd;
  logic                 want_adv;

  function automatic logic [owbm_pkg::CntW-1:0] seg_len(owbm_pkg::seq_state_t s,
                                                        owbm_pkg::cfg_t c);
    logic one;
    logic is_long;
    one     = s.shift_byte[0];
    is_long = (s.operation == owbm_pkg::OP_LONG);
    case (s.phase)
      owbm_pkg::PH_PRE:      seg_len = owbm_pkg::PRE_US;
      owbm_pkg::PH_RLOW:     seg_len = {6'b0, c.reset_low_us};
      owbm_pkg::PH_WAIT60:   seg_len = owbm_pkg::WAIT_US;
      owbm_pkg::PH_SAMPLE:   seg_len = owbm_pkg::SAMPLE_US;
      owbm_pkg::PH_HIGHWAIT: seg_len = owbm_pkg::HIGHWAIT_US - {10'b0, s.window_index[5:0]};
      owbm_pkg::PH_TAIL420:  seg_len = owbm_pkg::TAIL_US;
      owbm_pkg::PH_BITLOW: begin
        if (is_long) seg_len = one ? owbm_pkg::LONG_ONE_US : owbm_pkg::SLOT_LONG_US;
        else         seg_len = one ? owbm_pkg::SLOT_SHORT_US : owbm_pkg::SLOT_LONG_US;
      end
      owbm_pkg::PH_BITREL: begin
        if (is_long) seg_len = c.long_recovery_us;
        else         seg_len = one ? owbm_pkg::SLOT_LONG_US : owbm_pkg::SLOT_SHORT_US;
      end
      owbm_pkg::PH_RDLOW:    seg_len = owbm_pkg::RD_LOW_US;
      owbm_pkg::PH_RDREL:    seg_len = owbm_pkg::RD_REL_US;
      owbm_pkg::PH_RDREC:    seg_len = owbm_pkg::RD_REC_US;
      owbm_pkg::PH_BYTETAIL: seg_len = owbm_pkg::BYTE_TAIL_US;
      default:               seg_len = '0;
    endcase
  endfunction

  function automatic owbm_pkg::seq_step_t next_seg(owbm_pkg::seq_state_t s,
                                                   owbm_pkg::cfg_t c);
    owbm_pkg::seq_step_t r;
    logic [3:0]          total;
    r.st   = s;
    r.done = 1'b0;
    total  = (s.operation == owbm_pkg::OP_SLOT1 || s.operation == owbm_pkg::OP_SLOT0) ?
             owbm_pkg::BITS_PER_SLOT : owbm_pkg::BITS_PER_BYTE;
    case (s.phase)
      owbm_pkg::PH_PRE:    r.st.phase = owbm_pkg::PH_RLOW;
      owbm_pkg::PH_RLOW:   r.st.phase = owbm_pkg::PH_WAIT60;
      owbm_pkg::PH_WAIT60: begin
        r.st.window_index = '0;
        r.st.phase        = owbm_pkg::PH_SAMPLE;
      end
      owbm_pkg::PH_SAMPLE, owbm_pkg::PH_HIGHWAIT: r.st.phase = owbm_pkg::PH_TAIL420;
      owbm_pkg::PH_BITLOW: r.st.phase = owbm_pkg::PH_BITREL;
      owbm_pkg::PH_BITREL: begin
        r.st.bit_count  = s.bit_count + 4'd1;
        r.st.shift_byte = {1'b0, s.shift_byte[7:1]};
        if (r.st.bit_count >= total) begin
          if (s.operation == owbm_pkg::OP_WRITE) begin
            r.st.phase = owbm_pkg::PH_BYTETAIL;
          end else begin
            r.st.phase = owbm_pkg::PH_IDLE;
            r.done     = 1'b1;
          end
        end else begin
          r.st.phase = owbm_pkg::PH_BITLOW;
        end
      end
      owbm_pkg::PH_RDLOW: r.st.phase = owbm_pkg::PH_RDREL;
      owbm_pkg::PH_RDREL: r.st.phase = owbm_pkg::PH_RDREC;
      owbm_pkg::PH_RDREC: begin
        r.st.bit_count = s.bit_count + 4'd1;
        r.st.phase     = (r.st.bit_count >= owbm_pkg::BITS_PER_BYTE) ?
                         owbm_pkg::PH_BYTETAIL : owbm_pkg::PH_RDLOW;
      end
      default: begin
        r.st.phase = owbm_pkg::PH_IDLE;
        r.done     = 1'b1;
      end
    endcase
    if (r.done && s.operation == owbm_pkg::OP_READ) r.st.read_byte_reg = r.st.shift_byte;
    r.st.us_counter = seg_len(r.st, c);
    next_seg = r;
  endfunction

  always_comb begin
    is_cmd  = (item.op != owbm_pkg::OP_TICK) && (item.op != owbm_pkg::OP_UNUSED);
    s_start = state;
    if (is_cmd && state.phase == owbm_pkg::PH_IDLE) begin
      s_start.operation    = item.op;
      s_start.bit_count    = '0;
      s_start.window_index = '0;
      case (item.op)
        owbm_pkg::OP_RESET: begin
          s_start.presence_flag = 1'b0;
          s_start.shift_byte    = '0;
          s_start.phase         = owbm_pkg::PH_PRE;
        end
        owbm_pkg::OP_READ: begin
          s_start.shift_byte = '0;
          s_start.phase      = owbm_pkg::PH_RDLOW;
        end
        owbm_pkg::OP_SLOT1: begin
          s_start.shift_byte = 8'h01;
          s_start.phase      = owbm_pkg::PH_BITLOW;
        end
        owbm_pkg::OP_SLOT0: begin
          s_start.shift_byte = '0;
          s_start.phase      = owbm_pkg::PH_BITLOW;
        end
        default: begin
          s_start.shift_byte = item.data_byte;
          s_start.phase      = owbm_pkg::PH_BITLOW;
        end
      endcase
      s_start.us_counter = seg_len(s_start, cfg);
    end

    s_work   = s_start;
    want_adv = 1'b0;
    case (s_start.phase)
      owbm_pkg::PH_IDLE: ;
      owbm_pkg::PH_SAMPLE: begin
        if (!item.line_level) begin
          s_work.presence_flag = 1'b1;
          s_work.phase         = owbm_pkg::PH_HIGHWAIT;
          s_work.us_counter    = seg_len(s_work, cfg);
        end else begin
          s_work.window_index = s_start.window_index + 8'd1;
          if (s_start.us_counter != '0) s_work.us_counter = s_start.us_counter - 16'd1;
          want_adv = (s_work.window_index >= owbm_pkg::SAMPLE_WINDOW) ||
                     (s_work.us_counter == '0);
        end
      end
      owbm_pkg::PH_HIGHWAIT: begin
        if (item.line_level) begin
          want_adv = 1'b1;
        end else begin
          if (s_start.us_counter != '0) s_work.us_counter = s_start.us_counter - 16'd1;
          want_adv = (s_work.us_counter == '0);
        end
      end
      default: begin
        if (s_start.phase == owbm_pkg::PH_RDREL && s_start.us_counter <= 16'd1) begin
          s_work.shift_byte = {item.line_level, s_start.shift_byte[7:1]};
        end
        if (s_start.us_counter != '0) s_work.us_counter = s_start.us_counter - 16'd1;
        want_adv = (s_work.us_counter == '0);
      end
    endcase

    adv1 = next_seg(s_work, cfg);
    if (!adv1.done && adv1.st.us_counter == '0) adv2 = next_seg(adv1.st, cfg);
    else                                         adv2 = adv1;

    state_next = want_adv ? adv2.st : s_work;

    res.drive_low  = (s_start.phase == owbm_pkg::PH_RLOW) ||
                     (s_start.phase == owbm_pkg::PH_BITLOW) ||
                     (s_start.phase == owbm_pkg::PH_RDLOW);
    res.busy_res   = (state_next.phase != owbm_pkg::PH_IDLE);
    res.done_res   = want_adv && adv2.done;
    res.presence   = state_next.presence_flag;
    res.read_value = state_next.read_byte_reg;
    res.rejected   = is_cmd && (state.phase != owbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= owbm_pkg::PH_IDLE;
      state.operation     <= '0;
      state.us_counter    <= '0;
      state.window_index  <= '0;
      state.bit_count     <= '0;
      state.shift_byte    <= '0;
      state.presence_flag <= 1'b0;
      state.read_byte_reg <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

FILE: src/one_wire_bus_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Single-wire bus master advanced by one-microsecond items.
//
// Each transaction on the s_ channel is one microsecond of bus time: a plain
// tick or a command (reset, byte write, byte read, single slots, long-pulse
// byte). A command taken while idle starts an operation on that same
// microsecond; one taken while busy is flagged as rejected and ignored.
// Every input transaction yields exactly one m_ transaction carrying the
// drive-low level for that microsecond and the status flags.
// The cfg channel writes the reset pulse length (index 0) and the
// long-pulse recovery time (index 1); it is always ready. The user must write
// it only while no operation is running; the block itself does not enforce it.
// The sequencer step lies between the input and output registers; one item
// is taken per cycle while the receiver does not stall. While the receiver
// stalls, the result is held and at most one more item is absorbed by the
// input register before s_tready drops.
// Reset returns the sequencer to idle, clears presence and the read byte,
// and restores the default register values.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // data_byte[7:0], line_level[8], zero pad
  input  logic [2:0]                   s_tuser,   // op[2:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,   // drive_low, busy_res, done_res, presence,
                                                  // read_value[11:4], rejected[12], zero pad
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [owbm_pkg::RegIdxW-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);

  owbm_pkg::item_t   in_item;
  logic              in_vld;
  owbm_pkg::result_t out_res;
  owbm_pkg::result_t res;
  owbm_pkg::cfg_t    cfg;
  logic              fire;

  assign fire      = in_vld && (!m_tvalid || m_tready);
  assign s_tready  = !in_vld || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op         <= s_tuser;
      in_item.data_byte  <= s_tdata[7:0];
      in_item.line_level <= s_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.rejected, out_res.read_value, out_res.presence,
                    out_res.done_res, out_res.busy_res, out_res.drive_low};

  owbm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owbm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

FILE: src/owbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the single-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
